// ===== rtl/lftc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lftc_pkg
// Shared types, mode codes, register indexes and reset values of the
// line follower turn controller.
// ----------------------------------------------------------------------------
package lftc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int DUTY_BITS_DEFAULT   = 16;

   localparam int PATH_BITS      = 4;
   localparam int MODE_BITS      = 3;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_DUTY      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOW_DUTY      = 2'd2;

   localparam logic [31:0] LINE_THRESHOLD_RESET = 32'd600;
   localparam logic [31:0] FULL_DUTY_RESET      = 32'd65535;
   localparam logic [31:0] SLOW_DUTY_RESET      = 32'd16383;

   // free path bits
   localparam int PATH_FRONT = 0;
   localparam int PATH_RIGHT = 1;
   localparam int PATH_BACK  = 2;
   localparam int PATH_LEFT  = 3;

   typedef enum logic [7:0] {
      MODE_FOLLOW    = 8'b0000_0001,
      MODE_WAIT      = 8'b0000_0010,
      MODE_RIGHT     = 8'b0000_0100,
      MODE_RIGHT_CHK = 8'b0000_1000,
      MODE_LEFT      = 8'b0001_0000,
      MODE_LEFT_CHK  = 8'b0010_0000,
      MODE_UTURN     = 8'b0100_0000,
      MODE_UTURN_CHK = 8'b1000_0000
   } mode_type;

   localparam logic [MODE_BITS-1:0] CODE_FOLLOW    = 3'd0;
   localparam logic [MODE_BITS-1:0] CODE_WAIT      = 3'd1;
   localparam logic [MODE_BITS-1:0] CODE_RIGHT     = 3'd2;
   localparam logic [MODE_BITS-1:0] CODE_RIGHT_CHK = 3'd3;
   localparam logic [MODE_BITS-1:0] CODE_LEFT      = 3'd4;
   localparam logic [MODE_BITS-1:0] CODE_LEFT_CHK  = 3'd5;
   localparam logic [MODE_BITS-1:0] CODE_UTURN     = 3'd6;
   localparam logic [MODE_BITS-1:0] CODE_UTURN_CHK = 3'd7;

   typedef struct packed {
      mode_type mode;
      logic     on_line;
      logic     second_half;
   } ctl_type;

   function automatic logic [MODE_BITS-1:0] mode_code(input mode_type m);
      logic [MODE_BITS-1:0] code;
      case (m)
         MODE_FOLLOW:    code = CODE_FOLLOW;
         MODE_WAIT:      code = CODE_WAIT;
         MODE_RIGHT:     code = CODE_RIGHT;
         MODE_RIGHT_CHK: code = CODE_RIGHT_CHK;
         MODE_LEFT:      code = CODE_LEFT;
         MODE_LEFT_CHK:  code = CODE_LEFT_CHK;
         MODE_UTURN:     code = CODE_UTURN;
         MODE_UTURN_CHK: code = CODE_UTURN_CHK;
         default:        code = CODE_FOLLOW;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lftc_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lftc_step
// Next-state logic for one control tick: sensor compares, mode update,
// crossing decision and motor duties.
// ----------------------------------------------------------------------------
module lftc_step #(
   parameter int SAMPLE_BITS = lftc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int DUTY_BITS   = lftc_pkg::DUTY_BITS_DEFAULT
) (
   input  lftc_pkg::ctl_type               ctl,
   input  logic [DUTY_BITS-1:0]            held_a,
   input  logic [DUTY_BITS-1:0]            held_b,
   input  logic [SAMPLE_BITS-1:0]          line_threshold,
   input  logic [DUTY_BITS-1:0]            full_duty,
   input  logic [DUTY_BITS-1:0]            slow_duty,
   input  logic [SAMPLE_BITS-1:0]          right_sample,
   input  logic [SAMPLE_BITS-1:0]          left_sample,
   input  logic [SAMPLE_BITS-1:0]          cross_sample,
   input  logic [lftc_pkg::PATH_BITS-1:0]  free_paths,
   output lftc_pkg::ctl_type               ctl_next,
   output logic [DUTY_BITS-1:0]            duty_a_next,
   output logic [DUTY_BITS-1:0]            duty_b_next,
   output logic                            decided_next
);
   import lftc_pkg::*;

   localparam logic [DUTY_BITS-1:0] ZERO_DUTY = '0;

   logic                 right_on;
   logic                 left_on;
   logic                 cross_on;
   logic [DUTY_BITS-1:0] spin_a;
   logic [DUTY_BITS-1:0] spin_b;

   assign right_on = right_sample < line_threshold;
   assign left_on  = left_sample < line_threshold;
   assign cross_on = cross_sample < line_threshold;

   // right turn spins b, left and U turns spin a
   assign spin_a = (ctl.mode == MODE_RIGHT) ? ZERO_DUTY : full_duty;
   assign spin_b = (ctl.mode == MODE_RIGHT) ? full_duty : ZERO_DUTY;

   always_comb begin
      ctl_next     = ctl;
      duty_a_next  = held_a;
      duty_b_next  = held_b;
      decided_next = 1'b0;
      case (ctl.mode)
         MODE_FOLLOW: begin
            if (right_on && left_on) begin
               duty_a_next   = ZERO_DUTY;
               duty_b_next   = ZERO_DUTY;
               ctl_next.mode = MODE_WAIT;
            end else if (right_sample == left_sample) begin
               duty_a_next = full_duty;
               duty_b_next = full_duty;
            end else if (right_sample > left_sample) begin
               duty_a_next = full_duty;
               duty_b_next = slow_duty;
            end else begin
               duty_a_next = slow_duty;
               duty_b_next = full_duty;
            end
         end
         MODE_WAIT: begin
            if (!cross_on) begin
               duty_a_next = full_duty;
               duty_b_next = full_duty;
            end else begin
               duty_a_next      = ZERO_DUTY;
               duty_b_next      = ZERO_DUTY;
               ctl_next.on_line = 1'b1;
               decided_next     = |free_paths;
               if (free_paths[PATH_RIGHT]) begin
                  ctl_next.mode = MODE_RIGHT;
               end else if (free_paths[PATH_FRONT]) begin
                  ctl_next.mode = MODE_FOLLOW;
               end else if (free_paths[PATH_LEFT]) begin
                  ctl_next.mode = MODE_LEFT;
               end else if (free_paths[PATH_BACK]) begin
                  ctl_next.mode = MODE_UTURN;
               end
            end
         end
         MODE_RIGHT, MODE_LEFT, MODE_UTURN: begin
            if (ctl.on_line || !cross_on) begin
               duty_a_next = spin_a;
               duty_b_next = spin_b;
               if (!cross_on) begin
                  ctl_next.on_line = 1'b0;
               end
            end else begin
               // line crossed: turn step done
               duty_a_next      = ZERO_DUTY;
               duty_b_next      = ZERO_DUTY;
               ctl_next.on_line = 1'b1;
               if (ctl.mode == MODE_RIGHT) begin
                  ctl_next.mode = MODE_RIGHT_CHK;
               end else if (ctl.mode == MODE_LEFT) begin
                  ctl_next.mode = MODE_LEFT_CHK;
               end else if (ctl.second_half) begin
                  ctl_next.second_half = 1'b0;
                  ctl_next.mode        = MODE_UTURN_CHK;
               end else begin
                  ctl_next.second_half = 1'b1;
               end
            end
         end
         default: begin
            if (cross_on) begin
               duty_a_next = full_duty;
               duty_b_next = full_duty;
            end else begin
               ctl_next.mode    = MODE_FOLLOW;
               ctl_next.on_line = 1'b0;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/line_follower_turn_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_follower_turn_controller
// Takes one control tick per request (three reflectance samples and a mask of
// open ways) and returns one response with two motor duties, the mode after
// the tick and a crossing-decision flag. A request is taken every cycle unless
// a waiting response is stalled. The request is captured in the input
// register, and the tick logic loads the response register from it once that
// register is free to take a new response. The response register also holds
// the duties and mode kept between ticks.
// Registers: 0 line threshold, 1 full duty, 2 slow duty; csr_ready is always
// high and writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module line_follower_turn_controller #(
   parameter int SAMPLE_BITS = lftc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int DUTY_BITS   = lftc_pkg::DUTY_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lftc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [((SAMPLE_BITS > DUTY_BITS) ? SAMPLE_BITS : DUTY_BITS)-1:0] csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [SAMPLE_BITS-1:0]               req_right_sample,
   input  logic [SAMPLE_BITS-1:0]               req_left_sample,
   input  logic [SAMPLE_BITS-1:0]               req_cross_sample,
   input  logic [lftc_pkg::PATH_BITS-1:0]       req_free_paths,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [DUTY_BITS-1:0]                 rsp_duty_a,
   output logic [DUTY_BITS-1:0]                 rsp_duty_b,
   output logic [lftc_pkg::MODE_BITS-1:0]       rsp_mode,
   output logic                                 rsp_decided
);
   import lftc_pkg::*;

   logic [SAMPLE_BITS-1:0] line_threshold_ff;
   logic [DUTY_BITS-1:0]   full_duty_ff;
   logic [DUTY_BITS-1:0]   slow_duty_ff;

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_right_ff;
   logic [SAMPLE_BITS-1:0] s1_left_ff;
   logic [SAMPLE_BITS-1:0] s1_cross_ff;
   logic [PATH_BITS-1:0]   s1_paths_ff;

   logic                   out_valid_ff;
   logic                   out_valid_in;
   ctl_type                ctl_ff;
   ctl_type                ctl_in;
   logic [DUTY_BITS-1:0]   duty_a_ff;
   logic [DUTY_BITS-1:0]   duty_a_in;
   logic [DUTY_BITS-1:0]   duty_b_ff;
   logic [DUTY_BITS-1:0]   duty_b_in;
   logic                   decided_ff;
   logic                   decided_in;

   logic                   req_take;
   logic                   out_free;
   logic                   advance;

   assign csr_ready = 1'b1;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_threshold_ff <= SAMPLE_BITS'(LINE_THRESHOLD_RESET);
         full_duty_ff      <= DUTY_BITS'(FULL_DUTY_RESET);
         slow_duty_ff      <= DUTY_BITS'(SLOW_DUTY_RESET);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LINE_THRESHOLD: line_threshold_ff <= csr_data[SAMPLE_BITS-1:0];
            CSR_FULL_DUTY:      full_duty_ff      <= csr_data[DUTY_BITS-1:0];
            CSR_SLOW_DUTY:      slow_duty_ff      <= csr_data[DUTY_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_right_ff <= req_right_sample;
         s1_left_ff  <= req_left_sample;
         s1_cross_ff <= req_cross_sample;
         s1_paths_ff <= req_free_paths;
      end
   end

   lftc_step #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .DUTY_BITS   (DUTY_BITS)
   ) u_step (
      .ctl            (ctl_ff),
      .held_a         (duty_a_ff),
      .held_b         (duty_b_ff),
      .line_threshold (line_threshold_ff),
      .full_duty      (full_duty_ff),
      .slow_duty      (slow_duty_ff),
      .right_sample   (s1_right_ff),
      .left_sample    (s1_left_ff),
      .cross_sample   (s1_cross_ff),
      .free_paths     (s1_paths_ff),
      .ctl_next       (ctl_in),
      .duty_a_next    (duty_a_in),
      .duty_b_next    (duty_b_in),
      .decided_next   (decided_in)
   );

   // response register doubles as the held tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         ctl_ff.mode          <= MODE_FOLLOW;
         ctl_ff.on_line       <= 1'b0;
         ctl_ff.second_half   <= 1'b0;
         duty_a_ff            <= '0;
         duty_b_ff            <= '0;
         decided_ff           <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            ctl_ff     <= ctl_in;
            duty_a_ff  <= duty_a_in;
            duty_b_ff  <= duty_b_in;
            decided_ff <= decided_in;
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_duty_a  = duty_a_ff;
   assign rsp_duty_b  = duty_b_ff;
   assign rsp_mode    = mode_code(ctl_ff.mode);
   assign rsp_decided = decided_ff;

`ifndef SYNTH
   a_second_half_in_uturn: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.second_half |-> ctl_ff.mode == MODE_UTURN)
      else $error("second half flag set outside U turn");

   a_check_on_line: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.mode == MODE_RIGHT_CHK || ctl_ff.mode == MODE_LEFT_CHK ||
       ctl_ff.mode == MODE_UTURN_CHK) |-> ctl_ff.on_line)
      else $error("check mode without on-line flag");

   a_decided_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_decided) |->
         (rsp_duty_a == '0 && rsp_duty_b == '0 && rsp_mode != CODE_WAIT))
      else $error("crossing decision without stop or mode change");
`endif

endmodule
`default_nettype wire
